// ----- rtl/bc_pkg.sv -----
`timescale 1ns / 1ps
package bc_pkg;

  localparam int BC_COORD_BITS       = 12;
  localparam int BC_WEIGHT_FRAC_BITS = 14;
  localparam int BC_NUM_COORDS       = 12;
  localparam int BC_INT_BITS         = 6;

  localparam int BC_USER_DEGEN = 0;
  localparam int BC_USER_SAT   = 1;
  localparam int BC_USER_W     = 2;

endpackage

// ----- rtl/barycentric_coordinates.sv -----
`timescale 1ns / 1ps
// channel | dir | tdata (lowest bit up)                          | tuser
// in_     | in  | point_x,y,z, vertex_a_x..z, b_x..z, c_x..z      | -
// out_    | out | weight_a, weight_b, weight_c                    | degenerate, saturated
//
// One word accepted per cycle while the output is not stalled; the restoring divider
// produces one quotient bit per stage.
// Reset clears the valid bits only; data registers hold whatever they had.
// All stages move together when the output register is empty or being taken,
// so a stall freezes the whole pipe and in_tready follows out_tready.
module barycentric_coordinates import bc_pkg::*; #(
  parameter int COORD_BITS       = BC_COORD_BITS,
  parameter int WEIGHT_FRAC_BITS = BC_WEIGHT_FRAC_BITS,
  localparam int WB   = WEIGHT_FRAC_BITS + BC_INT_BITS,
  localparam int IN_W = ((BC_NUM_COORDS * COORD_BITS + 7) / 8) * 8,
  localparam int OUT_W = ((3 * WB + 7) / 8) * 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [IN_W-1:0]      in_tdata,   // point_x, point_y, point_z, vertex_a_x..z,
                                           // vertex_b_x..z, vertex_c_x..z
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [OUT_W-1:0]     out_tdata,  // weight_a, weight_b, weight_c
  output logic [BC_USER_W-1:0] out_tuser   // degenerate, saturated
);

  localparam int CB = COORD_BITS;
  localparam int E  = CB + 1;
  localparam int PW = 2 * E;
  localparam int DW = 2 * CB + 3;
  localparam int MW = 2 * DW;
  localparam int NW = MW + 1;
  localparam int QW = NW + WEIGHT_FRAC_BITS;
  localparam int RW = NW + 1;
  localparam int AW = RW + QW;
  localparam int XW = QW + 3;

  localparam logic signed [XW-1:0] ONE  = XW'(1) << WEIGHT_FRAC_BITS;
  localparam logic signed [XW-1:0] SMAX = {{(XW-WB+1){1'b0}}, {(WB-1){1'b1}}};
  localparam logic signed [XW-1:0] SMIN = {{(XW-WB+1){1'b1}}, {(WB-1){1'b0}}};

  function automatic logic [AW-1:0] div_step(input logic [AW-1:0] acc, input logic [NW-1:0] d);
    logic [AW-1:0] t;
    logic [RW-1:0] top;
    t   = acc << 1;
    top = t[AW-1 -: RW];
    if (top >= RW'(d)) begin
      t[AW-1 -: RW] = top - RW'(d);
      t[0] = 1'b1;
    end
    return t;
  endfunction

  logic en;
  assign en = !out_tvalid || out_tready;
  assign in_tready = en;

  // stage 1: edge vectors
  logic signed [E-1:0] c [BC_NUM_COORDS];
  logic signed [E-1:0] e0_nxt [3], e1_nxt [3], e2_nxt [3];
  logic signed [E-1:0] e0_r [3], e1_r [3], e2_r [3];

  always_comb begin
    for (int k = 0; k < BC_NUM_COORDS; k++) begin
      c[k] = E'(signed'(in_tdata[k*CB +: CB]));
    end
    for (int i = 0; i < 3; i++) begin
      e0_nxt[i] = c[6+i] - c[3+i];
      e1_nxt[i] = c[9+i] - c[3+i];
      e2_nxt[i] = c[i]   - c[3+i];
    end
  end

  // stage 2: component products
  logic signed [PW-1:0] p00_r [3], p01_r [3], p11_r [3], p20_r [3], p21_r [3];
  // stage 3: dot products
  logic signed [DW-1:0] d00_r, d01_r, d11_r, d20_r, d21_r;
  // stage 4: products of dot products
  logic signed [MW-1:0] m0011_r, m0101_r, m1120_r, m0121_r, m0021_r, m0120_r;
  // stage 5: determinant and numerators
  logic signed [NW-1:0] den_r, nv_r, nw_r;
  // divider pipe
  logic [AW-1:0] accv_r [QW+1];
  logic [AW-1:0] accw_r [QW+1];
  logic [NW-1:0] dd_r   [QW+1];
  logic          negv_r [QW+1];
  logic          negw_r [QW+1];
  logic          dg_r   [QW+1];
  // final stages
  logic signed [QW:0] qv_r, qw_r;
  logic               dgf_r;
  logic [5:0]         vld_r;
  logic [QW:0]        vd_r;

  logic signed [XW-1:0] qu_s, qv_s, qw_s;
  logic [WB-1:0]        wa, wb, wc;
  logic                 cla, clb, clc;

  always_comb begin
    qv_s = XW'(qv_r);
    qw_s = XW'(qw_r);
    qu_s = ONE - qv_s - qw_s;
    cla = (qu_s > SMAX) || (qu_s < SMIN);
    clb = (qv_s > SMAX) || (qv_s < SMIN);
    clc = (qw_s > SMAX) || (qw_s < SMIN);
    wa = (qu_s > SMAX) ? SMAX[WB-1:0] : (qu_s < SMIN) ? SMIN[WB-1:0] : qu_s[WB-1:0];
    wb = (qv_s > SMAX) ? SMAX[WB-1:0] : (qv_s < SMIN) ? SMIN[WB-1:0] : qv_s[WB-1:0];
    wc = (qw_s > SMAX) ? SMAX[WB-1:0] : (qw_s < SMIN) ? SMIN[WB-1:0] : qw_s[WB-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        e0_r[i]  <= e0_nxt[i];
        e1_r[i]  <= e1_nxt[i];
        e2_r[i]  <= e2_nxt[i];
        p00_r[i] <= PW'(e0_r[i]) * PW'(e0_r[i]);
        p01_r[i] <= PW'(e0_r[i]) * PW'(e1_r[i]);
        p11_r[i] <= PW'(e1_r[i]) * PW'(e1_r[i]);
        p20_r[i] <= PW'(e2_r[i]) * PW'(e0_r[i]);
        p21_r[i] <= PW'(e2_r[i]) * PW'(e1_r[i]);
      end
      d00_r <= DW'(p00_r[0]) + DW'(p00_r[1]) + DW'(p00_r[2]);
      d01_r <= DW'(p01_r[0]) + DW'(p01_r[1]) + DW'(p01_r[2]);
      d11_r <= DW'(p11_r[0]) + DW'(p11_r[1]) + DW'(p11_r[2]);
      d20_r <= DW'(p20_r[0]) + DW'(p20_r[1]) + DW'(p20_r[2]);
      d21_r <= DW'(p21_r[0]) + DW'(p21_r[1]) + DW'(p21_r[2]);
      m0011_r <= MW'(d00_r) * MW'(d11_r);
      m0101_r <= MW'(d01_r) * MW'(d01_r);
      m1120_r <= MW'(d11_r) * MW'(d20_r);
      m0121_r <= MW'(d01_r) * MW'(d21_r);
      m0021_r <= MW'(d00_r) * MW'(d21_r);
      m0120_r <= MW'(d01_r) * MW'(d20_r);
      den_r <= NW'(m0011_r) - NW'(m0101_r);
      nv_r  <= NW'(m1120_r) - NW'(m0121_r);
      nw_r  <= NW'(m0021_r) - NW'(m0120_r);
      accv_r[0] <= {{RW{1'b0}}, (nv_r < 0) ? NW'(-nv_r) : NW'(nv_r), {WEIGHT_FRAC_BITS{1'b0}}};
      accw_r[0] <= {{RW{1'b0}}, (nw_r < 0) ? NW'(-nw_r) : NW'(nw_r), {WEIGHT_FRAC_BITS{1'b0}}};
      dd_r[0]   <= den_r;
      negv_r[0] <= nv_r < 0;
      negw_r[0] <= nw_r < 0;
      dg_r[0]   <= den_r == '0;
      for (int k = 0; k < QW; k++) begin
        accv_r[k+1] <= div_step(accv_r[k], dd_r[k]);
        accw_r[k+1] <= div_step(accw_r[k], dd_r[k]);
        dd_r[k+1]   <= dd_r[k];
        negv_r[k+1] <= negv_r[k];
        negw_r[k+1] <= negw_r[k];
        dg_r[k+1]   <= dg_r[k];
      end
      qv_r  <= negv_r[QW] ? -signed'({1'b0, accv_r[QW][QW-1:0]})
                          :  signed'({1'b0, accv_r[QW][QW-1:0]});
      qw_r  <= negw_r[QW] ? -signed'({1'b0, accw_r[QW][QW-1:0]})
                          :  signed'({1'b0, accw_r[QW][QW-1:0]});
      dgf_r <= dg_r[QW];
      if (dgf_r) begin
        out_tdata <= '0;
        out_tuser <= BC_USER_W'(1) << BC_USER_DEGEN;
      end else begin
        out_tdata <= OUT_W'({wc, wb, wa});
        out_tuser <= BC_USER_W'(cla || clb || clc) << BC_USER_SAT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r      <= '0;
      vd_r       <= '0;
      out_tvalid <= 1'b0;
    end else if (en) begin
      vld_r      <= {vld_r[4:0], in_tvalid};
      vd_r       <= {vd_r[QW-1:0], vld_r[5]};
      out_tvalid <= vd_r[QW];
    end
  end

endmodule

// ----- rtl/bc_checker.sv -----
`timescale 1ns / 1ps
module bc_checker import bc_pkg::*; #(
  parameter int OUT_W = 64
) (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_tready,
  input logic                 out_tvalid,
  input logic                 out_tready,
  input logic [OUT_W-1:0]     out_tdata,
  input logic [BC_USER_W-1:0] out_tuser
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("output word changed under stall");

  a_degen: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[BC_USER_DEGEN] |-> out_tdata == '0 && !out_tuser[BC_USER_SAT])
    else $error("degenerate word carries weights or saturation");

  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready == (!out_tvalid || out_tready))
    else $error("pipe enable mismatch");

  a_rst: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  a_nowait: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output");

endmodule

bind barycentric_coordinates bc_checker #(.OUT_W(OUT_W)) u_bc_checker (
  .clk(clk), .rst_n(rst_n), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
  .out_tuser(out_tuser)
);
